@@ src/gcd_pkg.sv @@
// ----------------------------------------------------------------------------
// gcd_pkg
// Types, constants and helper functions shared by the great-circle distance
// datapath and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    // Reciprocal of 9e8 scaled by 2^62, split for two narrow multipliers.
    localparam logic [33:0] RECIP_9E8   = 34'd5124095576;
    localparam logic [16:0] RECIP_HI    = RECIP_9E8[32:16];
    localparam logic [15:0] RECIP_LO    = RECIP_9E8[15:0];
    localparam logic [31:0] DIV_9E8     = 32'd900000000;
    localparam logic [31:0] HALF_9E8    = 32'd450000000;

    localparam logic signed [63:0] HALF_PI_Q30   = 64'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
    localparam logic signed [63:0] Q30_HALF      = 64'sd536870912;
    localparam logic [30:0]        Q30_ONE       = 31'd1073741824;
    localparam logic [63:0]        TWO_RADIUS_M  = 64'd12742000;
    localparam logic [24:0]        MAX_DIST_M    = 25'd20015087;

    localparam logic signed [32:0] ATAN_HEAD [10] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149
    };

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [32:0] atan_step(input int i);
        logic signed [32:0] r;
        if (i < 10) begin
            r = ATAN_HEAD[i];
        end
        else if (i <= 30) begin
            r = 33'sd1 <<< (30 - i);
        end
        else begin
            r = 33'sd0;
        end
        return r;
    endfunction

    // Drops 30 fraction bits, rounding half away from zero.
    function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] r;
        if (p[63]) begin
            r = -((-p + Q30_HALF) >>> 30);
        end
        else begin
            r = (p + Q30_HALF) >>> 30;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/great_circle_distance_core.sv @@
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine distance between two points on a sphere of radius 6371 km.
// ----------------------------------------------------------------------------
// A request carries two points (lat_a, lon_a, lat_b, lon_b) in units of
// 1e-7 degree and is taken at a rising edge where start is high and busy is
// low. busy never rises: the datapath is a pipeline that takes one request
// every clock cycle.
// The result appears on distance_m, in whole metres, for exactly one cycle
// with done high. The delay from request to result is set by the two
// CORDIC chains (N stages each, where N is CORDIC_STAGES capped at 32,
// default 24), the 31-stage square root and the phase conversion and
// product stages around them.
// Results leave in request order, one per request. The receiver cannot stall
// the block, so nothing is held back.
// Reset clears the valid bits of all stages; requests in flight are dropped
// and done stays low until a new request has passed the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_core
    import gcd_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [30:0] lat_a,
    input  wire logic signed [31:0] lon_a,
    input  wire logic signed [30:0] lat_b,
    input  wire logic signed [31:0] lon_b,
    output logic                    done,
    output logic [24:0]             distance_m
);

    localparam int N       = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LATENCY = 45 + 2 * N;

    logic [LATENCY-1:0] vld_reg;

    // Phase conversion, lanes: lat_a, lon_a, lat_b, lon_b.
    logic signed [31:0] in_sx [4];
    logic [31:0]        in_mag [4];
    logic [48:0]        p1_hi_reg [4];
    logic [47:0]        p1_lo_reg [4];
    logic [1:0]         p1_xlo_reg [4];
    logic               p1_neg_reg [4];
    logic [31:0]        p2_q0_reg [4];
    logic [1:0]         p2_xlo_reg [4];
    logic               p2_neg_reg [4];
    logic [31:0]        p3_q0_reg [4];
    logic [31:0]        p3_rem_reg [4];
    logic               p3_neg_reg [4];
    logic [31:0]        p4_ph_reg [4];

    // Angles for sine and cosine: lat_a, lat_b, half dlat, half dlon.
    logic [31:0]        p5_ang_reg [4];
    logic signed [63:0] p6_prod_reg [4];
    logic               p6_flip_reg [4];

    logic signed [33:0] rx_reg [N+1][4];
    logic signed [33:0] ry_reg [N+1][4];
    logic signed [32:0] rz_reg [N+1][4];
    logic               rf_reg [N+1][4];

    logic signed [32:0] sc_ca_reg, sc_cb_reg, sc_sl_reg, sc_so_reg;
    logic signed [63:0] m1_ll_reg, m1_cc_reg, m1_oo_reg;
    logic signed [32:0] m2_ll_reg, m2_cc_reg, m2_oo_reg;
    logic signed [63:0] m3_prod_reg;
    logic signed [32:0] m3_ll_reg;
    logic [30:0]        hav_reg;
    logic signed [33:0] hav_sum;

    // Square roots: lane 0 of a, lane 1 of 1 - a.
    logic [61:0]        sq_r_reg [1:31][2];
    logic [30:0]        sq_q_reg [1:31][2];

    logic signed [33:0] vx_reg [1:N];
    logic signed [33:0] vy_reg [1:N];
    logic signed [32:0] vz_reg [1:N];

    logic [63:0]        d1_prod_reg;
    logic [63:0]        d_round;
    logic [24:0]        distance_m_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start};
        end
    end

    assign in_sx[0] = 32'(lat_a);
    assign in_sx[1] = lon_a;
    assign in_sx[2] = 32'(lat_b);
    assign in_sx[3] = lon_b;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            in_mag[l] = in_sx[l][31] ? (~in_sx[l] + 32'd1) : in_sx[l];
        end
    end

    // Phase = round(v * 2^32 / 3.6e9): reciprocal estimate, then one
    // remainder check, since the estimate is at most one below.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            p1_hi_reg[l]  <= 49'(in_mag[l]) * 49'(RECIP_HI);
            p1_lo_reg[l]  <= 48'(in_mag[l]) * 48'(RECIP_LO);
            p1_xlo_reg[l] <= in_mag[l][1:0];
            p1_neg_reg[l] <= in_sx[l][31];

            p2_q0_reg[l]  <= 32'((65'(p1_hi_reg[l]) << 16) + 65'(p1_lo_reg[l]) >> 32);
            p2_xlo_reg[l] <= p1_xlo_reg[l];
            p2_neg_reg[l] <= p1_neg_reg[l];

            p3_rem_reg[l] <= {p2_xlo_reg[l], 30'd0} + HALF_9E8 - p2_q0_reg[l] * DIV_9E8;
            p3_q0_reg[l]  <= p2_q0_reg[l];
            p3_neg_reg[l] <= p2_neg_reg[l];

            p4_ph_reg[l]  <= p3_neg_reg[l]
                ? (32'd0 - (p3_q0_reg[l] + 32'(p3_rem_reg[l] >= DIV_9E8)))
                : (p3_q0_reg[l] + 32'(p3_rem_reg[l] >= DIV_9E8));
        end
    end

    always_ff @(posedge clk)
    begin
        p5_ang_reg[0] <= p4_ph_reg[0];
        p5_ang_reg[1] <= p4_ph_reg[2];
        p5_ang_reg[2] <= (p4_ph_reg[2] - p4_ph_reg[0]) >> 1;
        p5_ang_reg[3] <= (p4_ph_reg[3] - p4_ph_reg[1]) >> 1;
    end

    // Fold the angle into [-1/4, 1/4) turn; the half turn is put back by
    // negating the results, then scale to Q30 radians.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            p6_flip_reg[l] <= (p5_ang_reg[l] + 32'h4000_0000) >> 31 != 32'd0;
            p6_prod_reg[l] <= 64'($signed(p5_ang_reg[l]
                                  ^ {((p5_ang_reg[l] + 32'h4000_0000) >> 31) != 32'd0,
                                     31'd0}))
                              * HALF_PI_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            rx_reg[0][l] <= CORDIC_GAIN;
            ry_reg[0][l] <= 34'sd0;
            rz_reg[0][l] <= 33'(round_q30(p6_prod_reg[l]));
            rf_reg[0][l] <= p6_flip_reg[l];
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [32:0] ATAN_I = atan_step(i);

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (!rz_reg[i][l][32])
                begin
                    rx_reg[i+1][l] <= rx_reg[i][l] - (ry_reg[i][l] >>> i);
                    ry_reg[i+1][l] <= ry_reg[i][l] + (rx_reg[i][l] >>> i);
                    rz_reg[i+1][l] <= rz_reg[i][l] - ATAN_I;
                end
                else
                begin
                    rx_reg[i+1][l] <= rx_reg[i][l] + (ry_reg[i][l] >>> i);
                    ry_reg[i+1][l] <= ry_reg[i][l] - (rx_reg[i][l] >>> i);
                    rz_reg[i+1][l] <= rz_reg[i][l] + ATAN_I;
                end
                rf_reg[i+1][l] <= rf_reg[i][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sc_ca_reg <= rf_reg[N][0] ? -33'(rx_reg[N][0]) : 33'(rx_reg[N][0]);
        sc_cb_reg <= rf_reg[N][1] ? -33'(rx_reg[N][1]) : 33'(rx_reg[N][1]);
        sc_sl_reg <= rf_reg[N][2] ? -33'(ry_reg[N][2]) : 33'(ry_reg[N][2]);
        sc_so_reg <= rf_reg[N][3] ? -33'(ry_reg[N][3]) : 33'(ry_reg[N][3]);
    end

    // a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2), each product
    // rounded back to Q30.
    always_ff @(posedge clk)
    begin
        m1_ll_reg   <= 64'(sc_sl_reg) * 64'(sc_sl_reg);
        m1_cc_reg   <= 64'(sc_ca_reg) * 64'(sc_cb_reg);
        m1_oo_reg   <= 64'(sc_so_reg) * 64'(sc_so_reg);

        m2_ll_reg   <= 33'(round_q30(m1_ll_reg));
        m2_cc_reg   <= 33'(round_q30(m1_cc_reg));
        m2_oo_reg   <= 33'(round_q30(m1_oo_reg));

        m3_prod_reg <= 64'(m2_cc_reg) * 64'(m2_oo_reg);
        m3_ll_reg   <= m2_ll_reg;
    end

    assign hav_sum = 34'(m3_ll_reg) + 34'(round_q30(m3_prod_reg));

    always_ff @(posedge clk)
    begin
        if (hav_sum[33])
        begin
            hav_reg <= 31'd0;
        end
        else if (hav_sum > 34'(Q30_ONE))
        begin
            hav_reg <= Q30_ONE;
        end
        else
        begin
            hav_reg <= 31'(hav_sum);
        end
    end

    // Square roots of a * 2^30 and (1 - a) * 2^30, one root bit per stage.
    for (genvar j = 0; j < 31; j++)
    begin : g_sqrt
        localparam int K = 30 - j;
        logic [61:0] rem_in [2];
        logic [30:0] root_in [2];
        logic [62:0] trial [2];

        if (j == 0)
        begin : g_first
            assign rem_in[0]  = 62'({hav_reg, 30'd0});
            assign rem_in[1]  = 62'({Q30_ONE - hav_reg, 30'd0});
            assign root_in[0] = 31'd0;
            assign root_in[1] = 31'd0;
        end
        else
        begin : g_next
            assign rem_in[0]  = sq_r_reg[j][0];
            assign rem_in[1]  = sq_r_reg[j][1];
            assign root_in[0] = sq_q_reg[j][0];
            assign root_in[1] = sq_q_reg[j][1];
        end

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = (63'(root_in[l]) << (K + 1)) + (63'd1 << (2 * K));
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (63'(rem_in[l]) >= trial[l])
                begin
                    sq_r_reg[j+1][l] <= 62'(63'(rem_in[l]) - trial[l]);
                    sq_q_reg[j+1][l] <= root_in[l] | (31'd1 << K);
                end
                else
                begin
                    sq_r_reg[j+1][l] <= rem_in[l];
                    sq_q_reg[j+1][l] <= root_in[l];
                end
            end
        end
    end

    // Half the central angle, atan2(sqrt(a), sqrt(1-a)), in Q30 radians by vectoring.
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam logic signed [32:0] ATAN_I = atan_step(i);
        logic signed [33:0] x_in, y_in;
        logic signed [32:0] z_in;

        if (i == 0)
        begin : g_first
            assign x_in = 34'(sq_q_reg[31][1]);
            assign y_in = 34'(sq_q_reg[31][0]);
            assign z_in = 33'sd0;
        end
        else
        begin : g_next
            assign x_in = vx_reg[i];
            assign y_in = vy_reg[i];
            assign z_in = vz_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (!y_in[33])
            begin
                vx_reg[i+1] <= x_in + (y_in >>> i);
                vy_reg[i+1] <= y_in - (x_in >>> i);
                vz_reg[i+1] <= z_in + ATAN_I;
            end
            else
            begin
                vx_reg[i+1] <= x_in - (y_in >>> i);
                vy_reg[i+1] <= y_in + (x_in >>> i);
                vz_reg[i+1] <= z_in - ATAN_I;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d1_prod_reg <= vz_reg[N][32] ? 64'd0 : 64'(vz_reg[N]) * TWO_RADIUS_M;
    end

    assign d_round = (d1_prod_reg + 64'(Q30_HALF)) >> 30;

    always_ff @(posedge clk)
    begin
        distance_m_reg <= (d_round > 64'(MAX_DIST_M)) ? MAX_DIST_M : 25'(d_round);
    end

    assign done       = vld_reg[LATENCY-1];
    assign distance_m = distance_m_reg;

endmodule

`default_nettype wire

@@ src/gcd_checker.sv @@
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks of the great-circle distance core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_checker
    import gcd_pkg::*;
#(
    parameter int LATENCY = 93
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [24:0] distance_m
);

    // The pipeline never pushes back.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised by a pipeline that cannot stall");

    // Every request gives a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request produced no result at the expected cycle");

    // No result without a matching request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a request");

    // Distances never exceed half the circumference.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> distance_m <= MAX_DIST_M)
        else $error("distance above half the circumference");

endmodule

bind great_circle_distance_core gcd_checker #(.LATENCY(LATENCY)) u_gcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .distance_m (distance_m)
);

`default_nettype wire
